// ===== rtl/paged_kv_gather_address_translate_core_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef PAGED_KV_GATHER_ADDRESS_TRANSLATE_CORE_ASSERT_SVH
`define PAGED_KV_GATHER_ADDRESS_TRANSLATE_CORE_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define KVAT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition checked in the cycle after the antecedent.
`define KVAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kvat_pkg.sv =====
// ----------------------------------------------------------------------------
// kvat_pkg
// Types and constants of the paged KV gather address translation block.
// ----------------------------------------------------------------------------
package kvat_pkg;

    // Request operation codes, carried on s_axis_tuser.
    typedef enum logic [1:0] {
        OP_POOL_WR = 2'd0,
        OP_SRC_WR  = 2'd1,
        OP_DST_WR  = 2'd2,
        OP_GATHER  = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 3'd0,
        CFG_SRC_WIDTH   = 3'd1,
        CFG_DST_WIDTH   = 3'd2,
        CFG_POOL_CAP    = 3'd3,
        CFG_SRC_BLOCKS  = 3'd4,
        CFG_DST_BLOCKS  = 3'd5,
        CFG_KV_ELEMS    = 3'd6,
        CFG_ROPE_ELEMS  = 3'd7
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POOL,
        ST_DIV,
        ST_TBL,
        ST_MUL,
        ST_DONE
    } state_t;

    // Field widths.
    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int WORD_W  = 32;
    localparam int BS_W    = 16;
    localparam int TW_CFG_W = 7;
    localparam int CAP_W   = 9;
    localparam int CNT_W   = 25;
    localparam int ELEM_W  = 16;
    localparam int PHYS_W  = 25;
    localparam int TOK_W   = 40;
    localparam int ELOFF_W = 56;
    localparam int DIV_W   = 31;
    localparam int DIV_CNT_W = 5;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 336;

    // Register reset values.
    localparam logic [BS_W-1:0]     RST_BLOCK_SIZE = 16'd128;
    localparam logic [TW_CFG_W-1:0] RST_TBL_WIDTH  = 7'd64;
    localparam logic [CAP_W-1:0]    RST_POOL_CAP   = 9'd256;
    localparam logic [CNT_W-1:0]    RST_BLOCKS     = 25'd16777216;
    localparam logic [ELEM_W-1:0]   RST_KV_ELEMS   = 16'd512;
    localparam logic [ELEM_W-1:0]   RST_ROPE_ELEMS = 16'd64;

endpackage

// ===== rtl/paged_kv_gather_address_translate_core.sv =====
// One request is handled at a time. A write or an early-rejected request goes
// from acceptance to ST_DONE and then the output register; a full gather goes
// through ST_POOL, ST_DIV (bit-serial dividers), ST_TBL, ST_MUL and ST_DONE.
// A finished result waits in the output register while the next is accepted.
// Reset (rst_n, async, active low) restores the registers to their defaults and
// clears the copy counter; the table memories keep their contents.
// ----------------------------------------------------------------------------
// paged_kv_gather_address_translate_core
// Translates gather requests into token and element offsets through the
// request-to-pool map and the source and destination block tables.
// ----------------------------------------------------------------------------
module paged_kv_gather_address_translate_core
#(
    parameter int MAX_REQUESTS    = 256,
    parameter int MAX_POOL_ROWS   = 256,
    parameter int MAX_TABLE_WIDTH = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Request channel.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata from bit 0: row, column, write_value, missed, token_position,
    // dest_slot, one zero pad bit.
    input  logic [kvat_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: op.
    input  logic [1:0]                       s_axis_tuser,
    // Result channel.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata from bit 0: source_token_offset, dest_token_offset,
    // source_kv_offset, dest_kv_offset, source_rope_offset, dest_rope_offset,
    // copy_count.
    output logic [kvat_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: copy_valid.
    output logic                             m_axis_tuser,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [kvat_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [kvat_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import kvat_pkg::*;

    localparam int RQ_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int PR_W  = (MAX_POOL_ROWS > 1) ? $clog2(MAX_POOL_ROWS) : 1;
    localparam int TW_W  = (MAX_TABLE_WIDTH > 1) ? $clog2(MAX_TABLE_WIDTH) : 1;
    localparam int SRC_DEPTH = MAX_POOL_ROWS * MAX_TABLE_WIDTH;
    localparam int DST_DEPTH = MAX_REQUESTS * MAX_TABLE_WIDTH;
    localparam int SA_W  = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
    localparam int DA_W  = (DST_DEPTH > 1) ? $clog2(DST_DEPTH) : 1;

    // Configuration registers.
    logic [BS_W-1:0]     bs_reg;
    logic [TW_CFG_W-1:0] stw_reg;
    logic [TW_CFG_W-1:0] dtw_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    sblk_reg;
    logic [CNT_W-1:0]    dblk_reg;
    logic [ELEM_W-1:0]   kv_reg;
    logic [ELEM_W-1:0]   rope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg   <= RST_BLOCK_SIZE;
            stw_reg  <= RST_TBL_WIDTH;
            dtw_reg  <= RST_TBL_WIDTH;
            cap_reg  <= RST_POOL_CAP;
            sblk_reg <= RST_BLOCKS;
            dblk_reg <= RST_BLOCKS;
            kv_reg   <= RST_KV_ELEMS;
            rope_reg <= RST_ROPE_ELEMS;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_BLOCK_SIZE: bs_reg   <= cfg_wdata[BS_W-1:0];
                CFG_SRC_WIDTH:  stw_reg  <= cfg_wdata[TW_CFG_W-1:0];
                CFG_DST_WIDTH:  dtw_reg  <= cfg_wdata[TW_CFG_W-1:0];
                CFG_POOL_CAP:   cap_reg  <= cfg_wdata[CAP_W-1:0];
                CFG_SRC_BLOCKS: sblk_reg <= cfg_wdata[CNT_W-1:0];
                CFG_DST_BLOCKS: dblk_reg <= cfg_wdata[CNT_W-1:0];
                CFG_KV_ELEMS:   kv_reg   <= cfg_wdata[ELEM_W-1:0];
                CFG_ROPE_ELEMS: rope_reg <= cfg_wdata[ELEM_W-1:0];
                default:        bs_reg   <= bs_reg;
            endcase
        end
    end

    // Unpack the request.
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [WORD_W-1:0] in_wv;
    logic              in_missed;
    logic [WORD_W-1:0] in_tok;
    logic [WORD_W-1:0] in_slot;
    op_t               in_op;
    logic [16:0]       row_ext;
    logic [12:0]       col_ext;
    logic              row_ok;
    logic              col_ok;

    assign in_row    = s_axis_tdata[7:0];
    assign in_col    = s_axis_tdata[13:8];
    assign in_wv     = s_axis_tdata[45:14];
    assign in_missed = s_axis_tdata[46];
    assign in_tok    = s_axis_tdata[78:47];
    assign in_slot   = s_axis_tdata[110:79];
    assign in_op     = op_t'(s_axis_tuser);
    assign row_ext   = 17'(in_row);
    assign col_ext   = 13'(in_col);
    assign row_ok    = (32'(in_row) < 32'(MAX_REQUESTS));
    assign col_ok    = (32'(in_col) < 32'(MAX_TABLE_WIDTH));

    // Sequencer state and working registers.
    state_t            state_reg;
    state_t            state_next;
    logic              ok_reg;
    logic              ok_next;
    logic [RQ_W-1:0]   req_reg;
    logic [WORD_W-1:0] pe_reg;
    logic [DIV_W-1:0]  sl_q;
    logic [DIV_W-1:0]  dl_q;
    logic [BS_W-1:0]   so_r;
    logic [BS_W-1:0]   do_r;
    logic              sdiv_busy;
    logic              ddiv_busy;
    logic [TOK_W-1:0]  st_reg;
    logic [TOK_W-1:0]  dt_reg;
    logic [ELOFF_W-1:0] skv_reg;
    logic [ELOFF_W-1:0] dkv_reg;
    logic [ELOFF_W-1:0] srp_reg;
    logic [ELOFF_W-1:0] drp_reg;
    logic [WORD_W-1:0] copies_reg;

    logic              accept;
    logic              div_start;
    logic              pool_wr;
    logic              src_wr;
    logic              dst_wr;
    logic              tbl_rd;
    logic              out_load;
    logic              out_free;
    logic              pre_ok;
    logic              pe_ok;
    logic              lb_ok;
    logic              phys_ok;

    // Memories and their registered read data.
    logic [WORD_W-1:0] pool_mem [MAX_REQUESTS];
    logic [WORD_W-1:0] src_mem  [SRC_DEPTH];
    logic [WORD_W-1:0] dst_mem  [DST_DEPTH];
    logic [WORD_W-1:0] pool_rd_reg;
    logic [WORD_W-1:0] src_rd_reg;
    logic [WORD_W-1:0] dst_rd_reg;
    logic [SA_W-1:0]   src_wa;
    logic [DA_W-1:0]   dst_wa;
    logic [SA_W-1:0]   src_ra;
    logic [DA_W-1:0]   dst_ra;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    // Write addresses: op 1 indexes by pool row, op 2 by request; then read addresses.
    assign src_wa = SA_W'(row_ext[PR_W-1:0]) * SA_W'(MAX_TABLE_WIDTH)
                  + SA_W'(col_ext[TW_W-1:0]);
    assign dst_wa = DA_W'(row_ext[RQ_W-1:0]) * DA_W'(MAX_TABLE_WIDTH)
                  + DA_W'(col_ext[TW_W-1:0]);
    assign src_ra = SA_W'(pe_reg[PR_W-1:0]) * SA_W'(MAX_TABLE_WIDTH)
                  + SA_W'(sl_q[TW_W-1:0]);
    assign dst_ra = DA_W'(req_reg) * DA_W'(MAX_TABLE_WIDTH)
                  + DA_W'(dl_q[TW_W-1:0]);

    // Checks at each step of a gather.
    assign pre_ok  = row_ok && in_missed && !in_tok[WORD_W-1] && !in_slot[WORD_W-1]
                  && (bs_reg != '0);
    assign pe_ok   = !pool_rd_reg[WORD_W-1]
                  && (pool_rd_reg < 32'(cap_reg))
                  && (pool_rd_reg < 32'(MAX_POOL_ROWS));
    assign lb_ok   = (32'(sl_q) < 32'(stw_reg)) && (32'(sl_q) < 32'(MAX_TABLE_WIDTH))
                  && (32'(dl_q) < 32'(dtw_reg)) && (32'(dl_q) < 32'(MAX_TABLE_WIDTH));
    assign phys_ok = !src_rd_reg[WORD_W-1] && !dst_rd_reg[WORD_W-1]
                  && (src_rd_reg < 32'(sblk_reg)) && (dst_rd_reg < 32'(dblk_reg));

    // Next state and control.
    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        div_start  = 1'b0;
        pool_wr    = 1'b0;
        src_wr     = 1'b0;
        dst_wr     = 1'b0;
        tbl_rd     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_POOL_WR:
                        begin
                            pool_wr    = row_ok;
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                        OP_SRC_WR:
                        begin
                            src_wr     = (32'(in_row) < 32'(MAX_POOL_ROWS)) && col_ok;
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                        OP_DST_WR:
                        begin
                            dst_wr     = row_ok && col_ok;
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            ok_next    = pre_ok;
                            div_start  = pre_ok;
                            state_next = pre_ok ? ST_POOL : ST_DONE;
                        end
                    endcase
                end
            end
            ST_POOL:
            begin
                ok_next    = pe_ok;
                state_next = pe_ok ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (!sdiv_busy && !ddiv_busy)
                begin
                    ok_next    = lb_ok;
                    tbl_rd     = lb_ok;
                    state_next = lb_ok ? ST_TBL : ST_DONE;
                end
            end
            ST_TBL:
            begin
                ok_next    = phys_ok;
                state_next = phys_ok ? ST_MUL : ST_DONE;
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ok_reg     <= 1'b0;
            copies_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            if (out_load && ok_reg)
            begin
                copies_reg <= copies_reg + 1'b1;
            end
        end
    end

    // Request index and pool entry captured for the table reads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= row_ext[RQ_W-1:0];
        end
        if (state_reg == ST_POOL)
        begin
            pe_reg <= pool_rd_reg;
        end
    end

    // Memory ports: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (pool_wr)
        begin
            pool_mem[row_ext[RQ_W-1:0]] <= in_wv;
        end
        pool_rd_reg <= pool_mem[row_ext[RQ_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (src_wr)
        begin
            src_mem[src_wa] <= in_wv;
        end
        if (tbl_rd)
        begin
            src_rd_reg <= src_mem[src_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dst_wr)
        begin
            dst_mem[dst_wa] <= in_wv;
        end
        if (tbl_rd)
        begin
            dst_rd_reg <= dst_mem[dst_ra];
        end
    end

    // Split position and slot into logical block and offset.
    kvat_div u_sdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_tok[DIV_W-1:0]),
        .divisor   (bs_reg),
        .busy      (sdiv_busy),
        .quotient  (sl_q),
        .remainder (so_r)
    );

    kvat_div u_ddiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_slot[DIV_W-1:0]),
        .divisor   (bs_reg),
        .busy      (ddiv_busy),
        .quotient  (dl_q),
        .remainder (do_r)
    );

    // Token offsets in ST_TBL, then element offsets in ST_MUL.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TBL)
        begin
            st_reg <= TOK_W'(src_rd_reg[PHYS_W-1:0]) * TOK_W'(bs_reg) + TOK_W'(so_r);
            dt_reg <= TOK_W'(dst_rd_reg[PHYS_W-1:0]) * TOK_W'(bs_reg) + TOK_W'(do_r);
        end
        if (state_reg == ST_MUL)
        begin
            skv_reg <= ELOFF_W'(st_reg) * ELOFF_W'(kv_reg);
            dkv_reg <= ELOFF_W'(dt_reg) * ELOFF_W'(kv_reg);
            srp_reg <= ELOFF_W'(st_reg) * ELOFF_W'(rope_reg);
            drp_reg <= ELOFF_W'(dt_reg) * ELOFF_W'(rope_reg);
        end
    end

    // Output register.
    logic                 mvalid_reg;
    logic                 muser_reg;
    logic [M_TDATA_W-1:0] mdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            mvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            muser_reg <= ok_reg;
            if (ok_reg)
            begin
                mdata_reg <= {copies_reg + 1'b1, drp_reg, srp_reg, dkv_reg, skv_reg,
                              dt_reg, st_reg};
            end
            else
            begin
                mdata_reg <= {copies_reg, (M_TDATA_W - WORD_W)'(0)};
            end
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = muser_reg;
    assign m_axis_tdata  = mdata_reg;

endmodule

// ===== rtl/kvat_div.sv =====
// ----------------------------------------------------------------------------
// kvat_div
// Restoring divider, one quotient bit per cycle, 31-bit dividend by 16 bits.
// ----------------------------------------------------------------------------
module kvat_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kvat_pkg::DIV_W-1:0]  dividend,
    input  logic [kvat_pkg::BS_W-1:0]   divisor,
    output logic                        busy,
    output logic [kvat_pkg::DIV_W-1:0]  quotient,
    output logic [kvat_pkg::BS_W-1:0]   remainder
);
    import kvat_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [BS_W-1:0]      rem_reg;
    logic [BS_W-1:0]      rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [BS_W-1:0]      div_reg;
    logic [BS_W:0]        trial;
    logic [BS_W:0]        diff;
    logic                 ge;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/kvat_checker.sv =====
// ----------------------------------------------------------------------------
// kvat_checker
// Port-level checks of the gather translation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "paged_kv_gather_address_translate_core_assert.svh"

module kvat_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [kvat_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                             m_axis_tuser
);
    import kvat_pkg::*;

    // A stalled result stays and keeps its payload.
    `KVAT_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `KVAT_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // One request at a time: no acceptance in the cycle after one.
    `KVAT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

    // A result without a copy carries zero offsets.
    `KVAT_ASSERT_IMPL(a_zero_offsets, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[303:0] == '0, "offsets set on a failed request")

endmodule

bind paged_kv_gather_address_translate_core kvat_checker u_kvat_checker (.*);

// ===== verif/paged_kv_gather_address_translate_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_kv_gather_address_translate_core_tb
// Self-checking bench for the paged KV gather address translator. It first
// fills the pool map and block table rows that gathers use, then walks a table
// of directed requests and runs random request mixes under several register
// settings. Each result is compared with a predictor that mirrors the tables.
// ----------------------------------------------------------------------------
module paged_kv_gather_address_translate_core_tb;

    import kvat_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 50;

    // One request as it travels on the request channel.
    typedef struct {
        op_t         op;
        bit [7:0]    row;
        bit [5:0]    column;
        bit [31:0]   write_value;
        bit          missed;
        bit [31:0]   token_position;
        bit [31:0]   dest_slot;
    } request_t;

    // One translation result.
    typedef struct {
        bit          copy_valid;
        bit [39:0]   src_tok;
        bit [39:0]   dst_tok;
        bit [55:0]   src_kv;
        bit [55:0]   dst_kv;
        bit [55:0]   src_rope;
        bit [55:0]   dst_rope;
        bit [31:0]   copy_count;
    } translation_t;

    // Directed row: when known is set the expected result is a plain
    // no-copy result with the given counter value.
    typedef struct {
        request_t    req;
        bit          known;
        bit [31:0]   count;
    } directed_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata;
    logic [1:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [M_TDATA_W-1:0]     m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_addr;
    logic [CFG_DATA_W-1:0]    cfg_wdata;

    // Predictor state.
    bit [15:0]    blk_size;
    bit [6:0]     src_width;
    bit [6:0]     dst_width;
    bit [8:0]     pool_cap;
    bit [24:0]    src_blocks;
    bit [24:0]    dst_blocks;
    bit [15:0]    kv_elems;
    bit [15:0]    rope_elems;
    bit [31:0]    pool_mirror [256];
    bit [31:0]    src_mirror [256][64];
    bit [31:0]    dst_mirror [256][64];
    bit [31:0]    copies_issued;

    translation_t pending_results [$];
    int           error_count;
    int           hold_off_cycles;
    bit           quiet;

    paged_kv_gather_address_translate_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result of a request that writes a store or fails a check.
    function automatic translation_t no_copy();
        translation_t res;
        res = '{default: '0};
        res.copy_count = copies_issued;
        return res;
    endfunction

    // Predicts the result of one accepted request and updates the mirrors.
    function automatic translation_t translate(request_t req);
        translation_t res;
        bit [31:0] pool_row_sel;
        bit [31:0] src_lblk;
        bit [31:0] src_off;
        bit [31:0] dst_lblk;
        bit [31:0] dst_off;
        bit [31:0] src_phys;
        bit [31:0] dst_phys;
        bit [63:0] src_lin;
        bit [63:0] dst_lin;
        case (req.op)
            OP_POOL_WR: pool_mirror[req.row] = req.write_value;
            OP_SRC_WR:  src_mirror[req.row][req.column] = req.write_value;
            OP_DST_WR:  dst_mirror[req.row][req.column] = req.write_value;
            default:    ;
        endcase
        if (req.op != OP_GATHER || !req.missed || req.token_position[31] ||
            req.dest_slot[31])
            return no_copy();
        pool_row_sel = pool_mirror[req.row];
        if (pool_row_sel[31] || pool_row_sel >= pool_cap || pool_row_sel >= 256 ||
            blk_size == 0)
            return no_copy();
        src_lblk = req.token_position / blk_size;
        src_off  = req.token_position % blk_size;
        dst_lblk = req.dest_slot / blk_size;
        dst_off  = req.dest_slot % blk_size;
        if (src_lblk >= src_width || src_lblk >= 64 ||
            dst_lblk >= dst_width || dst_lblk >= 64)
            return no_copy();
        src_phys = src_mirror[pool_row_sel][src_lblk];
        dst_phys = dst_mirror[req.row][dst_lblk];
        if (src_phys[31] || dst_phys[31] || src_phys >= src_blocks ||
            dst_phys >= dst_blocks)
            return no_copy();
        src_lin = 64'(src_phys) * blk_size + src_off;
        dst_lin = 64'(dst_phys) * blk_size + dst_off;
        copies_issued = copies_issued + 1;
        res.copy_valid = 1'b1;
        res.src_tok    = src_lin[39:0];
        res.dst_tok    = dst_lin[39:0];
        res.src_kv     = 56'(64'(res.src_tok) * kv_elems);
        res.dst_kv     = 56'(64'(res.dst_tok) * kv_elems);
        res.src_rope   = 56'(64'(res.src_tok) * rope_elems);
        res.dst_rope   = 56'(64'(res.dst_tok) * rope_elems);
        res.copy_count = copies_issued;
        return res;
    endfunction

    // Offers one request, waits for its acceptance and records the prediction.
    task automatic send_request(request_t req, bit known = 1'b0,
                                bit [31:0] known_count = '0);
        translation_t res;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {1'b0, req.dest_slot, req.token_position, req.missed,
                          req.write_value, req.column, req.row};
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        res = translate(req);
        if (known)
        begin
            res = '{default: '0};
            res.copy_count = known_count;
        end
        pending_results.push_back(res);
    endtask

    // Lets the block drain completely so registers may be written.
    task automatic wait_idle();
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Writes one configuration register and updates the predictor copy.
    // The write enable is left high; the caller drops it after the last write.
    task automatic write_reg(cfg_idx_t idx, bit [24:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_BLOCK_SIZE: blk_size   = value[15:0];
            CFG_SRC_WIDTH:  src_width  = value[6:0];
            CFG_DST_WIDTH:  dst_width  = value[6:0];
            CFG_POOL_CAP:   pool_cap   = value[8:0];
            CFG_SRC_BLOCKS: src_blocks = value;
            CFG_DST_BLOCKS: dst_blocks = value;
            CFG_KV_ELEMS:   kv_elems   = value[15:0];
            default:        rope_elems = value[15:0];
        endcase
    endtask

    task automatic apply_setting(bit [24:0] bs, bit [24:0] sw, bit [24:0] dw,
                                 bit [24:0] cap, bit [24:0] sb, bit [24:0] db,
                                 bit [24:0] kv, bit [24:0] rope);
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, bs);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_POOL_CAP, cap);
        write_reg(CFG_SRC_BLOCKS, sb);
        write_reg(CFG_DST_BLOCKS, db);
        write_reg(CFG_KV_ELEMS, kv);
        write_reg(CFG_ROPE_ELEMS, rope);
        cfg_we <= 1'b0;
    endtask

    // A position that mostly lands inside the table row under the setting.
    function automatic bit [31:0] position_in_row(bit [6:0] width);
        int unsigned lblk;
        int unsigned off;
        lblk = $urandom_range(0, (width > 64) ? 64 : width);
        off  = (blk_size == 0) ? $urandom_range(0, 300)
                               : $urandom_range(0, blk_size - 1);
        return lblk * blk_size + off;
    endfunction

    // Random request mix: table writes, well-formed gathers and noise.
    // Gathers use requests 0 and 1, whose rows are filled, and the pool map
    // only points them at the filled source rows or at invalid entries.
    task automatic random_requests(int count, bit quiet_tail);
        request_t req;
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            if (quiet_tail && i >= count - 150)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            req.op             = OP_GATHER;
            req.row            = 8'($urandom_range(0, 1));
            req.column         = 6'($urandom_range(0, 63));
            req.missed         = 1'b1;
            req.write_value    = (pick % 7 == 0) ? $urandom()
                                                 : $urandom_range(0, 4095);
            req.token_position = position_in_row(src_width);
            req.dest_slot      = position_in_row(dst_width);
            if (pick < 15)
            begin
                req.op = OP_POOL_WR;
                if (pick % 7 != 0)
                    req.write_value = $urandom_range(0, 1);
                else
                    req.write_value = $urandom() | 32'h0000_1000;
            end
            else if (pick < 30)
            begin
                req.op = OP_SRC_WR;
                if (pick % 3 == 0)
                    req.row = 8'($urandom_range(0, 255));
            end
            else if (pick < 45)
            begin
                req.op = OP_DST_WR;
                if (pick % 3 == 0)
                    req.row = 8'($urandom_range(0, 255));
            end
            else if (pick >= 85)
            begin
                req.missed         = 1'($urandom_range(0, 1));
                req.token_position = $urandom();
                req.dest_slot      = $urandom();
                if (pick >= 93)
                    req.token_position = req.token_position >> $urandom_range(0, 31);
            end
            send_request(req);
        end
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string field, logic [63:0] got,
                                   logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h",
                 $realtime, field, got, want);
        error_count++;
    endtask

    // Receiver: random back-pressure and comparison of each result.
    initial
    begin
        translation_t want;
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $realtime);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.copy_valid)
                        report_mismatch("copy_valid", m_axis_tuser, want.copy_valid);
                    if (m_axis_tdata[39:0] !== want.src_tok)
                        report_mismatch("src_token_offset", m_axis_tdata[39:0],
                                        want.src_tok);
                    if (m_axis_tdata[79:40] !== want.dst_tok)
                        report_mismatch("dest_token_offset", m_axis_tdata[79:40],
                                        want.dst_tok);
                    if (m_axis_tdata[135:80] !== want.src_kv)
                        report_mismatch("source_kv_offset", m_axis_tdata[135:80],
                                        want.src_kv);
                    if (m_axis_tdata[191:136] !== want.dst_kv)
                        report_mismatch("dest_kv_offset", m_axis_tdata[191:136],
                                        want.dst_kv);
                    if (m_axis_tdata[247:192] !== want.src_rope)
                        report_mismatch("source_rope_offset", m_axis_tdata[247:192],
                                        want.src_rope);
                    if (m_axis_tdata[303:248] !== want.dst_rope)
                        report_mismatch("dest_rope_offset", m_axis_tdata[303:248],
                                        want.dst_rope);
                    if (m_axis_tdata[335:304] !== want.copy_count)
                        report_mismatch("copy_count", m_axis_tdata[335:304],
                                        want.copy_count);
                end
            end
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        int stuck;
        stuck = 0;
        forever
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        directed_row_t directed [$];
        request_t req;
        bit passed;
        error_count     = 0;
        hold_off_cycles = 0;
        quiet           = 1'b0;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_POOL_WR;
        cfg_we          = 1'b0;
        cfg_addr        = CFG_BLOCK_SIZE;
        cfg_wdata       = '0;
        blk_size        = RST_BLOCK_SIZE;
        src_width       = RST_TBL_WIDTH;
        dst_width       = RST_TBL_WIDTH;
        pool_cap        = RST_POOL_CAP;
        src_blocks      = RST_BLOCKS;
        dst_blocks      = RST_BLOCKS;
        kv_elems        = RST_KV_ELEMS;
        rope_elems      = RST_ROPE_ELEMS;
        copies_issued   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the entries that random gathers can reach: requests 0 and 1,
        // source rows 0 and 1, every column.
        req = '{op: OP_POOL_WR, row: 0, column: 0, write_value: 0, missed: 0,
                token_position: 0, dest_slot: 0};
        for (int r = 0; r < 2; r++)
        begin
            req.op = OP_POOL_WR;
            req.row = 8'(r);
            req.write_value = $urandom_range(0, 1);
            send_request(req);
            for (int c = 0; c < 64; c++)
            begin
                req.column = 6'(c);
                req.op = OP_SRC_WR;
                req.write_value = $urandom_range(0, 4095);
                send_request(req);
                req.op = OP_DST_WR;
                req.write_value = $urandom_range(0, 4095);
                send_request(req);
            end
        end

        // Directed requests under the reset register values.
        directed = '{
            '{'{OP_GATHER, 8'd0, 6'd0, 32'd0, 1'b0, 32'd0, 32'd0}, 1, 0},
            '{'{OP_GATHER, 8'd1, 6'd0, 32'd0, 1'b1, 32'hFFFFFFFF, 32'd0}, 1, 0},
            '{'{OP_GATHER, 8'd1, 6'd0, 32'd0, 1'b1, 32'd0, 32'h80000000}, 1, 0},
            '{'{OP_POOL_WR, 8'd5, 6'd0, 32'd2, 1'b0, 32'd0, 32'd0}, 1, 0},
            '{'{OP_SRC_WR, 8'd2, 6'd0, 32'd3, 1'b0, 32'd0, 32'd0}, 1, 0},
            '{'{OP_DST_WR, 8'd5, 6'd1, 32'd7, 1'b0, 32'd0, 32'd0}, 1, 0},
            '{'{OP_GATHER, 8'd5, 6'd0, 32'd0, 1'b1, 32'd10, 32'd130}, 0, 0},
            '{'{OP_POOL_WR, 8'd255, 6'd0, 32'h80000000, 1'b0, 32'd0, 32'd0}, 1, 1},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'd0, 32'd0}, 1, 1},
            '{'{OP_POOL_WR, 8'd255, 6'd0, 32'h7FFFFFFF, 1'b0, 32'd0, 32'd0}, 1, 1},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'd0, 32'd0}, 1, 1},
            '{'{OP_POOL_WR, 8'd255, 6'd0, 32'd255, 1'b0, 32'd0, 32'd0}, 1, 1},
            '{'{OP_SRC_WR, 8'd255, 6'd63, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0}, 1, 1},
            '{'{OP_DST_WR, 8'd255, 6'd63, 32'd16777215, 1'b0, 32'd0, 32'd0}, 1, 1},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'd8191, 32'd8191}, 1, 1},
            '{'{OP_SRC_WR, 8'd255, 6'd63, 32'd16777215, 1'b0, 32'd0, 32'd0}, 1, 1},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'd8191, 32'd8191}, 0, 0},
            '{'{OP_DST_WR, 8'd255, 6'd63, 32'd16777216, 1'b0, 32'd0, 32'd0}, 1, 2},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'd8191, 32'd8191}, 1, 2},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'd8192, 32'd0}, 1, 2},
            '{'{OP_GATHER, 8'd255, 6'd0, 32'd0, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF},
              1, 2}
        };
        foreach (directed[i])
            send_request(directed[i].req, directed[i].known, directed[i].count);

        // Random phases across register settings; one long receiver stall.
        hold_off_cycles = 300;
        random_requests(250, 1'b0);
        apply_setting(1, 1, 1, 1, 25'h1FFFFFF, 25'h1FFFFFF, 65535, 65535);
        random_requests(100, 1'b0);
        apply_setting(65535, 64, 64, 256, 25'h1FFFFFF, 25'h1FFFFFF, 1, 1);
        random_requests(150, 1'b0);
        apply_setting(0, 127, 127, 511, 0, 0, 25'h1AAAA, 25'h15555);
        random_requests(80, 1'b0);
        apply_setting($urandom_range(1, 300), $urandom_range(1, 64),
                      $urandom_range(1, 64), $urandom_range(0, 256),
                      $urandom_range(0, 5000), $urandom_range(0, 5000),
                      $urandom_range(1, 65535), $urandom_range(1, 65535));
        random_requests(150, 1'b0);
        apply_setting(128, 64, 64, 256, 16777216, 16777216, 512, 64);
        random_requests(170, 1'b1);

        // Drain and report.
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        passed = (error_count == 0);
        if (passed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kvat_pkg.sv
rtl/kvat_div.sv
rtl/paged_kv_gather_address_translate_core.sv
rtl/kvat_checker.sv
verif/paged_kv_gather_address_translate_core_tb.sv
